@@ rtl/adx_pkg.sv @@
// Package for the trend-strength filter: widths, codes, payload structs and
// the sequencer state type. No dependencies.
package adx_pkg;

  localparam int PRICE_BITS    = 32;
  localparam int FRAC_BITS     = 16;
  localparam int RANGE_BITS    = PRICE_BITS + FRAC_BITS;
  localparam int RATIO_BITS    = 24;
  localparam int IDX_BITS      = 24;
  localparam int WEIGHT_BITS   = FRAC_BITS + 1;
  localparam int PERIOD_BITS   = 10;
  localparam int THRESH_BITS   = 23;
  localparam int CFG_IDX_BITS  = 2;
  localparam int CFG_DATA_BITS = 23;
  localparam int QUO_BITS      = 24;
  localparam int MUL_BITS      = RANGE_BITS + WEIGHT_BITS + 3;

  localparam int DEFAULT_PERIOD = 14;
  localparam int PERCENT        = 100;
  localparam int RESET_THRESH   = 1638400;
  localparam int RESET_WEIGHT   = ((2 << FRAC_BITS) + (DEFAULT_PERIOD + 1) / 2)
                                  / (DEFAULT_PERIOD + 1);
  localparam logic [RATIO_BITS-1:0] RATIO_MAX = '1;

  localparam logic [CFG_IDX_BITS-1:0] REG_PERIOD = 2'd0;
  localparam logic [CFG_IDX_BITS-1:0] REG_THRESH = 2'd1;

  typedef enum logic [1:0] {
    SIG_HOLD = 2'd0,
    SIG_BUY  = 2'd1,
    SIG_SELL = 2'd2
  } signal_t;

  typedef struct packed {
    logic [PRICE_BITS-1:0] high_price;
    logic [PRICE_BITS-1:0] low_price;
    logic [PRICE_BITS-1:0] prev_close_price;
  } bar_t;

  typedef struct packed {
    signal_t                     trade_signal;
    logic signed [IDX_BITS-1:0]  directional_index;
    logic signed [IDX_BITS-1:0]  average_index;
    logic                        zero_range_flag;
  } result_t;

  // Bar as queued between front and back, true range already worked out
  typedef struct packed {
    logic [PRICE_BITS-1:0] high_price;
    logic [PRICE_BITS-1:0] low_price;
    logic [PRICE_BITS-1:0] range_ticks;
  } qbar_t;

  typedef struct packed {
    logic [WEIGHT_BITS-1:0] weight;
    logic [THRESH_BITS-1:0] threshold;
  } cfg_t;

  typedef enum logic [3:0] {
    B_IDLE,
    B_PREP,
    B_RMUL,
    B_RATIO_P,
    B_DIVP,
    B_RATIO_M,
    B_DIVM,
    B_RBLEND,
    B_PMUL,
    B_MMUL,
    B_SUM,
    B_DIVX,
    B_XBLEND,
    B_XMUL,
    B_EMIT
  } back_state_t;

endpackage

@@ rtl/adx_front.sv @@
// Front end: takes bars, works out the true range, queues two entries.
// Uses adx_pkg.
module adx_front (
  input  logic                clk,
  input  logic                rst,
  input  logic                push,
  output logic                full,
  input  adx_pkg::bar_t       bar,
  output logic                q_valid,
  output adx_pkg::qbar_t      q_item,
  input  logic                q_pop
);

  logic [adx_pkg::PRICE_BITS-1:0] hl, hc, lc, tr;
  adx_pkg::qbar_t                 slots [2];
  logic                           wr_ptr, rd_ptr;
  logic [1:0]                     count;
  logic                           do_push;

  always_comb begin
    hl = (bar.high_price > bar.low_price) ? bar.high_price - bar.low_price : '0;
    hc = (bar.high_price > bar.prev_close_price) ?
         bar.high_price - bar.prev_close_price : bar.prev_close_price - bar.high_price;
    lc = (bar.low_price > bar.prev_close_price) ?
         bar.low_price - bar.prev_close_price : bar.prev_close_price - bar.low_price;
    tr = hl;
    if (hc > tr) begin
      tr = hc;
    end
    if (lc > tr) begin
      tr = lc;
    end
  end

  assign full    = (count == 2'd2);
  assign q_valid = (count != 2'd0);
  assign q_item  = slots[rd_ptr];
  assign do_push = push && !full;

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= '{high_price: bar.high_price, low_price: bar.low_price,
                         range_ticks: tr};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (do_push) begin
        wr_ptr <= !wr_ptr;
      end
      if (q_pop) begin
        rd_ptr <= !rd_ptr;
      end
      unique case ({do_push, q_pop})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

endmodule

@@ rtl/adx_cfg.sv @@
// Configuration registers; derives the smoothing weight 2/(n+1) in Q1.16
// with a bit-serial divider. Uses adx_pkg.
module adx_cfg (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [adx_pkg::CFG_IDX_BITS-1:0]    cfg_index,
  input  logic [adx_pkg::CFG_DATA_BITS-1:0]   cfg_data,
  output adx_pkg::cfg_t                       cfg
);

  localparam int DVD_BITS = adx_pkg::FRAC_BITS + 2;
  localparam int DEN_BITS = adx_pkg::PERIOD_BITS + 1;

  logic                   busy;
  logic [4:0]             cnt;
  logic [DVD_BITS-1:0]    dvd;
  logic [DVD_BITS-1:0]    quo;
  logic [DEN_BITS:0]      rem;
  logic [DEN_BITS-1:0]    den;
  logic [DEN_BITS-1:0]    den_in;
  logic [DEN_BITS:0]      trial;
  logic                   ge;
  logic [adx_pkg::PERIOD_BITS-1:0] n;
  logic                   wr;

  assign cfg_ready = !busy;
  assign wr        = cfg_valid && cfg_ready;
  assign n         = cfg_data[adx_pkg::PERIOD_BITS-1:0];
  assign den_in    = (n == '0) ? DEN_BITS'(adx_pkg::DEFAULT_PERIOD + 1)
                               : DEN_BITS'(n) + DEN_BITS'(1);
  assign trial     = {rem[DEN_BITS-1:0], dvd[DVD_BITS-1]};
  assign ge        = (trial >= {1'b0, den});

  always_ff @(posedge clk) begin
    if (rst) begin
      busy          <= 1'b0;
      cnt           <= '0;
      cfg.weight    <= adx_pkg::WEIGHT_BITS'(adx_pkg::RESET_WEIGHT);
      cfg.threshold <= adx_pkg::THRESH_BITS'(adx_pkg::RESET_THRESH);
    end else if (busy) begin
      rem <= ge ? trial - {1'b0, den} : trial;
      dvd <= dvd << 1;
      quo <= {quo[DVD_BITS-2:0], ge};
      cnt <= cnt + 5'd1;
      if (cnt == 5'(DVD_BITS - 1)) begin
        busy       <= 1'b0;
        cfg.weight <= adx_pkg::WEIGHT_BITS'({quo[DVD_BITS-2:0], ge});
      end
    end else if (wr) begin
      if (cfg_index == adx_pkg::REG_PERIOD) begin
        // numerator 2.0 in Q16 plus half the divisor, so the quotient rounds
        busy <= 1'b1;
        cnt  <= '0;
        den  <= den_in;
        rem  <= '0;
        quo  <= '0;
        dvd  <= DVD_BITS'(2 << adx_pkg::FRAC_BITS) + DVD_BITS'(den_in >> 1);
      end else if (cfg_index == adx_pkg::REG_THRESH) begin
        cfg.threshold <= cfg_data[adx_pkg::THRESH_BITS-1:0];
      end
    end
  end

endmodule

@@ rtl/adx_div.sv @@
// Shared restoring divider, one quotient bit per cycle, 24 bits.
// Uses adx_pkg.
module adx_div (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              start,
  input  logic [adx_pkg::RANGE_BITS-1:0]    rem_init,
  input  logic [adx_pkg::QUO_BITS-1:0]      low_init,
  input  logic [adx_pkg::RANGE_BITS-1:0]    den,
  output logic                              done,
  output logic [adx_pkg::QUO_BITS-1:0]      quo
);

  logic                               busy;
  logic [4:0]                         cnt;
  logic [adx_pkg::RANGE_BITS-1:0]     rem;
  logic [adx_pkg::QUO_BITS-1:0]       low;
  logic [adx_pkg::RANGE_BITS-1:0]     den_r;
  logic [adx_pkg::RANGE_BITS:0]       trial;
  logic [adx_pkg::RANGE_BITS:0]       diff;
  logic                               ge;

  assign trial = {rem, low[adx_pkg::QUO_BITS-1]};
  assign ge    = (trial >= {1'b0, den_r});
  assign diff  = trial - {1'b0, den_r};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy  <= 1'b1;
        cnt   <= '0;
        rem   <= rem_init;
        low   <= low_init;
        den_r <= den;
      end else if (busy) begin
        rem <= ge ? diff[adx_pkg::RANGE_BITS-1:0] : trial[adx_pkg::RANGE_BITS-1:0];
        low <= low << 1;
        quo <= {quo[adx_pkg::QUO_BITS-2:0], ge};
        cnt <= cnt + 5'd1;
        if (cnt == 5'(adx_pkg::QUO_BITS - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule

@@ rtl/adx_back.sv @@
// Back end: sequencer for one bar, shift-add smoothing multiplier, shared
// divider for ratios and index. Uses adx_pkg and adx_div.
module adx_back (
  input  logic                clk,
  input  logic                rst,
  input  adx_pkg::cfg_t       cfg,
  input  logic                q_valid,
  input  adx_pkg::qbar_t      q_item,
  output logic                q_pop,
  output logic                res_valid,
  input  logic                res_ready,
  output adx_pkg::result_t    res
);

  localparam int RB = adx_pkg::RANGE_BITS;
  localparam int MB = adx_pkg::MUL_BITS;
  localparam int QB = adx_pkg::RATIO_BITS;

  adx_pkg::back_state_t state, state_next;

  adx_pkg::qbar_t                   cur;
  logic [adx_pkg::PRICE_BITS-1:0]   last_high, last_low;
  logic [RB-1:0]                    range;
  logic [adx_pkg::PRICE_BITS-1:0]   up_r, down_r;
  logic [QB-1:0]                    tp, tm, plus_r, minus_r;
  logic signed [adx_pkg::IDX_BITS-1:0] sidx, dx;
  logic                             zero_r, neg_r;
  logic [1:0]                       bars_seen;
  logic                             seed;

  logic signed [MB-1:0]             mul_acc, mul_cand, mul_diff, mul_sh;
  logic [adx_pkg::WEIGHT_BITS-1:0]  mul_w;
  logic [4:0]                       mul_cnt;
  logic                             mul_done, mul_load;

  logic                             div_start, div_done;
  logic [RB-1:0]                    div_rem0, div_den;
  logic [adx_pkg::QUO_BITS-1:0]     div_low, div_quo;

  logic [RB-1:0]                    t_range, up_ext, down_ext;
  logic [QB:0]                      sum;
  logic [QB-1:0]                    adiff;
  logic [QB+6:0]                    pct;
  logic [RB-1:0]                    num;

  assign seed     = (bars_seen == 2'd1);
  assign t_range  = {cur.range_ticks, adx_pkg::FRAC_BITS'(0)};
  assign up_ext   = {8'd0, up_r, 8'd0};
  assign down_ext = {8'd0, down_r, 8'd0};
  assign sum      = {1'b0, plus_r} + {1'b0, minus_r};
  assign adiff    = (plus_r >= minus_r) ? plus_r - minus_r : minus_r - plus_r;
  assign pct      = (QB + 7)'(adiff) * (QB + 7)'(adx_pkg::PERCENT);
  // 100*diff in Q16 plus half the sum: the quotient rounds to nearest
  assign num      = {1'b0, pct, adx_pkg::FRAC_BITS'(0)} + RB'(sum >> 1);

  assign mul_done = (mul_cnt == 5'(adx_pkg::WEIGHT_BITS));
  assign mul_sh   = (mul_acc + MB'(1 << (adx_pkg::FRAC_BITS - 1))) >>> adx_pkg::FRAC_BITS;

  adx_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .rem_init (div_rem0),
    .low_init (div_low),
    .den      (div_den),
    .done     (div_done),
    .quo      (div_quo)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= adx_pkg::B_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    q_pop      = 1'b0;
    mul_load   = 1'b0;
    mul_diff   = '0;
    div_start  = 1'b0;
    div_rem0   = '0;
    div_low    = '0;
    div_den    = range;
    res_valid  = 1'b0;
    unique case (state)
      adx_pkg::B_IDLE: begin
        if (q_valid) begin
          q_pop      = 1'b1;
          state_next = (bars_seen == 2'd0) ? adx_pkg::B_EMIT : adx_pkg::B_PREP;
        end
      end
      adx_pkg::B_PREP: begin
        if (seed) begin
          state_next = adx_pkg::B_RATIO_P;
        end else begin
          mul_load   = 1'b1;
          mul_diff   = $signed(MB'(t_range)) - $signed(MB'(range));
          state_next = adx_pkg::B_RMUL;
        end
      end
      adx_pkg::B_RMUL: begin
        if (mul_done) begin
          state_next = adx_pkg::B_RATIO_P;
        end
      end
      adx_pkg::B_RATIO_P: begin
        if (range == '0 || up_ext >= range) begin
          state_next = adx_pkg::B_RATIO_M;
        end else begin
          div_start  = 1'b1;
          div_rem0   = up_ext;
          state_next = adx_pkg::B_DIVP;
        end
      end
      adx_pkg::B_DIVP: begin
        if (div_done) begin
          state_next = adx_pkg::B_RATIO_M;
        end
      end
      adx_pkg::B_RATIO_M: begin
        if (range == '0 || down_ext >= range) begin
          state_next = adx_pkg::B_RBLEND;
        end else begin
          div_start  = 1'b1;
          div_rem0   = down_ext;
          state_next = adx_pkg::B_DIVM;
        end
      end
      adx_pkg::B_DIVM: begin
        if (div_done) begin
          state_next = adx_pkg::B_RBLEND;
        end
      end
      adx_pkg::B_RBLEND: begin
        if (seed) begin
          state_next = adx_pkg::B_SUM;
        end else begin
          mul_load   = 1'b1;
          mul_diff   = $signed(MB'(tp)) - $signed(MB'(plus_r));
          state_next = adx_pkg::B_PMUL;
        end
      end
      adx_pkg::B_PMUL: begin
        if (mul_done) begin
          mul_load   = 1'b1;
          mul_diff   = $signed(MB'(tm)) - $signed(MB'(minus_r));
          state_next = adx_pkg::B_MMUL;
        end
      end
      adx_pkg::B_MMUL: begin
        if (mul_done) begin
          state_next = adx_pkg::B_SUM;
        end
      end
      adx_pkg::B_SUM: begin
        if (sum == '0) begin
          state_next = adx_pkg::B_XBLEND;
        end else begin
          div_start  = 1'b1;
          div_rem0   = RB'(num[RB-1:adx_pkg::QUO_BITS]);
          div_low    = num[adx_pkg::QUO_BITS-1:0];
          div_den    = RB'(sum);
          state_next = adx_pkg::B_DIVX;
        end
      end
      adx_pkg::B_DIVX: begin
        if (div_done) begin
          state_next = adx_pkg::B_XBLEND;
        end
      end
      adx_pkg::B_XBLEND: begin
        if (seed) begin
          state_next = adx_pkg::B_EMIT;
        end else begin
          mul_load   = 1'b1;
          mul_diff   = MB'(dx) - MB'(sidx);
          state_next = adx_pkg::B_XMUL;
        end
      end
      adx_pkg::B_XMUL: begin
        if (mul_done) begin
          state_next = adx_pkg::B_EMIT;
        end
      end
      adx_pkg::B_EMIT: begin
        res_valid = 1'b1;
        if (res_ready) begin
          state_next = adx_pkg::B_IDLE;
        end
      end
      default: state_next = adx_pkg::B_IDLE;
    endcase
  end

  // Smoothing: new = old + round(((now - old) * w) / 2^16), one weight bit a cycle
  always_ff @(posedge clk) begin
    if (rst) begin
      mul_cnt <= 5'(adx_pkg::WEIGHT_BITS);
    end else if (mul_load) begin
      mul_acc  <= '0;
      mul_cand <= mul_diff;
      mul_w    <= cfg.weight;
      mul_cnt  <= '0;
    end else if (!mul_done) begin
      if (mul_w[0]) begin
        mul_acc <= mul_acc + mul_cand;
      end
      mul_cand <= mul_cand <<< 1;
      mul_w    <= mul_w >> 1;
      mul_cnt  <= mul_cnt + 5'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      last_high <= '0;
      last_low  <= '0;
      range     <= '0;
      plus_r    <= '0;
      minus_r   <= '0;
      sidx      <= '0;
      bars_seen <= 2'd0;
      dx        <= '0;
      zero_r    <= 1'b0;
    end else begin
      unique case (state)
        adx_pkg::B_IDLE: begin
          if (q_pop) begin
            cur    <= q_item;
            dx     <= '0;
            zero_r <= 1'b0;
          end
        end
        adx_pkg::B_PREP: begin
          up_r   <= (cur.high_price > last_high) ? cur.high_price - last_high : '0;
          down_r <= (last_low > cur.low_price) ? last_low - cur.low_price : '0;
          if (seed) begin
            range <= t_range;
          end
        end
        adx_pkg::B_RMUL: begin
          if (mul_done) begin
            range <= range + mul_sh[RB-1:0];
          end
        end
        adx_pkg::B_RATIO_P: begin
          zero_r <= (range == '0);
          if (range == '0) begin
            tp <= '0;
          end else if (up_ext >= range) begin
            tp <= adx_pkg::RATIO_MAX;
          end
        end
        adx_pkg::B_DIVP: begin
          if (div_done) begin
            tp <= div_quo;
          end
        end
        adx_pkg::B_RATIO_M: begin
          if (range == '0) begin
            tm <= '0;
          end else if (down_ext >= range) begin
            tm <= adx_pkg::RATIO_MAX;
          end
        end
        adx_pkg::B_DIVM: begin
          if (div_done) begin
            tm <= div_quo;
          end
        end
        adx_pkg::B_RBLEND: begin
          if (seed) begin
            plus_r  <= tp;
            minus_r <= tm;
          end
        end
        adx_pkg::B_PMUL: begin
          if (mul_done) begin
            plus_r <= plus_r + mul_sh[QB-1:0];
          end
        end
        adx_pkg::B_MMUL: begin
          if (mul_done) begin
            minus_r <= minus_r + mul_sh[QB-1:0];
          end
        end
        adx_pkg::B_SUM: begin
          neg_r <= (plus_r < minus_r);
          if (sum == '0) begin
            dx <= '0;
          end
        end
        adx_pkg::B_DIVX: begin
          if (div_done) begin
            dx <= neg_r ? -$signed(div_quo) : $signed(div_quo);
          end
        end
        adx_pkg::B_XBLEND: begin
          if (seed) begin
            sidx <= dx;
          end
        end
        adx_pkg::B_XMUL: begin
          if (mul_done) begin
            sidx <= sidx + $signed(mul_sh[adx_pkg::IDX_BITS-1:0]);
          end
        end
        adx_pkg::B_EMIT: begin
          if (res_ready) begin
            last_high <= cur.high_price;
            last_low  <= cur.low_price;
            bars_seen <= (bars_seen == 2'd0) ? 2'd1 : 2'd2;
          end
        end
        default: ;
      endcase
    end
  end

  always_comb begin
    res.directional_index = dx;
    res.average_index     = sidx;
    res.zero_range_flag   = zero_r;
    if (dx == '0) begin
      res.trade_signal = adx_pkg::SIG_HOLD;
    end else if (sidx > $signed({1'b0, cfg.threshold})) begin
      res.trade_signal = adx_pkg::SIG_BUY;
    end else begin
      res.trade_signal = adx_pkg::SIG_SELL;
    end
  end

endmodule

@@ rtl/adx_trend_strength_filter.sv @@
// Top level of the ADX trend-strength filter: front queue, configuration,
// back sequencer and output register. Uses adx_pkg and all adx_ modules.
//
// Usage:
//  - Bars go in on push/full/bar: a transfer happens on a rising edge with
//    push high and full low. Two bars can wait in the front queue.
//  - Results come out on empty/pop/result: the oldest result sits on result
//    while empty is low and leaves on an edge with pop high.
//  - Configuration: cfg_valid/cfg_ready with cfg_index and cfg_data. Index 0
//    sets the period (the weight is then derived while cfg_ready is low),
//    index 1 the buy threshold; other indexes are dropped.
//  - Timing: the first bar after reset only primes the history and yields a
//    hold result with zero indexes. The second bar seeds the averages without
//    the bit-serial smoothing multiplier; later bars use it four times. Both
//    use the shared 24-step divider up to three times; a division is skipped
//    for a zero range, a saturated ratio or a zero sum. One bar at a time.
//  - Reset clears all history, the queue and the output register, and
//    restores period 14 and the default threshold.
//  - If the receiver stalls, one result waits in the output register, the
//    back end holds the next one, and the front queue keeps taking bars
//    until its two slots fill, then full rises.
module adx_trend_strength_filter (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                push,
  output logic                                full,
  input  adx_pkg::bar_t                       bar,
  output logic                                empty,
  input  logic                                pop,
  output adx_pkg::result_t                    result,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [adx_pkg::CFG_IDX_BITS-1:0]    cfg_index,
  input  logic [adx_pkg::CFG_DATA_BITS-1:0]   cfg_data
);

  logic               q_valid, q_pop;
  adx_pkg::qbar_t     q_item;
  adx_pkg::cfg_t      cfg;
  logic               res_valid, res_ready;
  adx_pkg::result_t   res;
  logic               out_full;

  adx_front u_front (
    .clk     (clk),
    .rst     (rst),
    .push    (push),
    .full    (full),
    .bar     (bar),
    .q_valid (q_valid),
    .q_item  (q_item),
    .q_pop   (q_pop)
  );

  adx_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  adx_back u_back (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .q_valid   (q_valid),
    .q_item    (q_item),
    .q_pop     (q_pop),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res       (res)
  );

  // single output register; refilled in the same cycle it is popped
  assign res_ready = !out_full || pop;
  assign empty     = !out_full;

  always_ff @(posedge clk) begin
    if (res_valid && res_ready) begin
      result <= res;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_full <= 1'b0;
    end else if (res_valid && res_ready) begin
      out_full <= 1'b1;
    end else if (pop) begin
      out_full <= 1'b0;
    end
  end

endmodule
